@@ hw/rtl/mts_pkg.sv @@
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the mixed-type subtractor.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam logic [1:0] TAG_UNSIGNED = 2'd0;
  localparam logic [1:0] TAG_SIGNED   = 2'd1;
  localparam logic [1:0] TAG_DOUBLE   = 2'd2;
  localparam logic [1:0] TAG_UNKNOWN  = 2'd3;

  localparam logic [63:0] QNAN = 64'hFFF8000000000000;

  // unpacked binary64 operand: exponent in biased form, 64-bit significand
  // with the leading one at bit 63 (or below for subnormals / zero)
  typedef struct packed {
    logic        sign;
    logic [11:0] exp;
    logic [63:0] sig;
    logic        zero;
    logic        inf;
    logic        nan;
  } mts_op_t;

  function automatic logic [5:0] lzc64(input logic [63:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd0;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(63 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/mixed_type_subtractor_unit.sv @@
// ----------------------------------------------------------------------------
// mixed_type_subtractor_unit
// Subtracts two type-tagged 64-bit operands (unsigned, signed or binary64).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_ready with tag_a, bits_a, tag_b, bits_b.
//   Output channel: out_valid / out_ready with valid_res, result_tag and
//   result_bits. One result per request, in request order.
//   The pipeline has five register stages: unpack and integer-to-double
//   conversion, alignment, add, normalize, round. One request is accepted
//   every cycle while the output is taken.
//   When out_ready is low, the stages hold; a stage with an empty slot still
//   advances, so bubbles are squeezed out before the pipe stops accepting.
//   rst clears all stage valid bits; payload registers are not reset.
//   Integer results travel down the pipe unchanged alongside the float path.
//   NaN results are the default quiet NaN, or the quieted NaN operand with
//   operand a taking precedence.
// ----------------------------------------------------------------------------
module mixed_type_subtractor_unit
  import mts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  tag_a,
  input  logic [63:0] bits_a,
  input  logic [1:0]  tag_b,
  input  logic [63:0] bits_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        valid_res,
  output logic [1:0]  result_tag,
  output logic [63:0] result_bits
);

  // stage enables
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;
  assign en5 = !v5 || out_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // ---------------- stage 1: classify, integer path, unpack ----------------
  function automatic mts_op_t unpack(input logic [1:0] tag, input logic [63:0] b);
    mts_op_t    o;
    logic [63:0] mag;
    logic [5:0]  lz;
    logic [63:0] n;
    logic        up;
    logic [53:0] r;
    o = '0;
    if (tag == TAG_DOUBLE) begin
      o.sign = b[63];
      o.inf  = (b[62:52] == 11'h7FF) && (b[51:0] == '0);
      o.nan  = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
      o.zero = (b[62:0] == '0);
      if (b[62:52] == '0) begin
        o.exp = 12'd1;
        o.sig = {1'b0, b[51:0], 11'b0};
      end else begin
        o.exp = {1'b0, b[62:52]};
        o.sig = {1'b1, b[51:0], 11'b0};
      end
    end else begin
      o.sign = (tag == TAG_SIGNED) && b[63];
      mag    = o.sign ? (~b + 64'd1) : b;
      lz     = lzc64(mag);
      o.zero = (mag == '0);
      n      = mag << lz;
      // round to 53 bits, nearest even
      up     = n[10] && ((|n[9:0]) || n[11]);
      r      = {1'b0, n[63:11]} + {53'd0, up};
      if (o.zero) begin
        o.sig = '0;
        o.exp = 12'd1;
      end else if (r[53]) begin
        o.sig = {1'b1, 63'd0};
        o.exp = 12'd1087 - {6'd0, lz};
      end else begin
        o.sig = {r[52:0], 11'd0};
        o.exp = 12'd1086 - {6'd0, lz};
      end
    end
    return o;
  endfunction

  logic        s1_known, s1_fp;
  logic [1:0]  s1_itag;
  logic [63:0] s1_idiff, s1_ba, s1_bb;
  mts_op_t     s1_a, s1_b;

  always_ff @(posedge clk) begin
    logic [63:0] idiff;
    if (en1) begin
      idiff = bits_a - bits_b;
      s1_known <= (tag_a != TAG_UNKNOWN) && (tag_b != TAG_UNKNOWN);
      s1_fp    <= (tag_a == TAG_DOUBLE) || (tag_b == TAG_DOUBLE);
      s1_idiff <= idiff;
      if (tag_a == TAG_UNSIGNED && tag_b == TAG_UNSIGNED)
        s1_itag <= (bits_a < bits_b) ? TAG_SIGNED : TAG_UNSIGNED;
      else
        s1_itag <= idiff[63] ? TAG_SIGNED : TAG_UNSIGNED;
      s1_a  <= unpack(tag_a, bits_a);
      s1_b  <= unpack(tag_b, bits_b);
      s1_ba <= bits_a;
      s1_bb <= bits_b;
    end
  end

  // ---------------- stage 2: special cases, order, align ----------------
  logic        s2_known, s2_fp, s2_special, s2_sub, s2_sign;
  logic [1:0]  s2_itag;
  logic [63:0] s2_idiff, s2_spec;
  logic [11:0] s2_exp;
  logic [66:0] s2_big, s2_small;

  always_ff @(posedge clk) begin
    logic        sb, swap;
    logic [11:0] d;
    logic [66:0] sm, sh;
    logic        stk;
    if (en2) begin
      s2_known <= s1_known;
      s2_fp    <= s1_fp;
      s2_itag  <= s1_itag;
      s2_idiff <= s1_idiff;
      sb = !s1_b.sign;
      s2_special <= s1_a.nan || s1_b.nan || s1_a.inf || s1_b.inf;
      if (s1_a.nan)
        s2_spec <= s1_ba | 64'h0008000000000000;
      else if (s1_b.nan)
        s2_spec <= s1_bb | 64'h0008000000000000;
      else if (s1_a.inf && s1_b.inf && (s1_a.sign == sb))
        s2_spec <= {s1_a.sign, 11'h7FF, 52'd0};
      else if (s1_a.inf && s1_b.inf)
        s2_spec <= QNAN;
      else if (s1_a.inf)
        s2_spec <= {s1_a.sign, 11'h7FF, 52'd0};
      else
        s2_spec <= {sb, 11'h7FF, 52'd0};
      swap = (s1_b.exp > s1_a.exp) ||
             ((s1_b.exp == s1_a.exp) && (s1_b.sig > s1_a.sig));
      s2_sub  <= (s1_a.sign != sb);
      s2_sign <= swap ? sb : s1_a.sign;
      s2_exp  <= swap ? s1_b.exp : s1_a.exp;
      s2_big  <= {1'b0, (swap ? s1_b.sig : s1_a.sig), 2'b0};
      sm = {1'b0, (swap ? s1_a.sig : s1_b.sig), 2'b0};
      d  = swap ? (s1_b.exp - s1_a.exp) : (s1_a.exp - s1_b.exp);
      if (d > 12'd66) begin
        sh  = '0;
        stk = (sm != '0);
      end else begin
        sh  = sm >> d[6:0];
        stk = ((sh << d[6:0]) != sm);
      end
      s2_small <= {sh[66:1], sh[0] | stk};
    end
  end

  // ---------------- stage 3: add / subtract ----------------
  logic        s3_known, s3_fp, s3_special, s3_sign, s3_sub;
  logic [1:0]  s3_itag;
  logic [63:0] s3_idiff, s3_spec;
  logic [11:0] s3_exp;
  logic [66:0] s3_sum;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_known   <= s2_known;
      s3_fp      <= s2_fp;
      s3_itag    <= s2_itag;
      s3_idiff   <= s2_idiff;
      s3_special <= s2_special;
      s3_spec    <= s2_spec;
      s3_sign    <= s2_sign;
      s3_sub     <= s2_sub;
      s3_exp     <= s2_exp;
      s3_sum     <= s2_sub ? (s2_big - s2_small) : (s2_big + s2_small);
    end
  end

  // ---------------- stage 4: normalize ----------------
  logic        s4_known, s4_fp, s4_special, s4_sign, s4_zero;
  logic [1:0]  s4_itag;
  logic [63:0] s4_idiff, s4_spec;
  logic [12:0] s4_exp;
  logic [66:0] s4_sig;

  always_ff @(posedge clk) begin
    logic [5:0]  lz;
    logic [12:0] e;
    logic [6:0]  sh;
    if (en4) begin
      s4_known   <= s3_known;
      s4_fp      <= s3_fp;
      s4_itag    <= s3_itag;
      s4_idiff   <= s3_idiff;
      s4_special <= s3_special;
      s4_spec    <= s3_spec;
      s4_zero    <= (s3_sum == '0);
      s4_sign    <= (s3_sum == '0) ? (s3_sign & !s3_sub) : s3_sign;
      if (s3_sum[66]) begin
        s4_sig <= {1'b0, s3_sum[66:2], s3_sum[1] | s3_sum[0]};
        s4_exp <= {1'b0, s3_exp} + 13'd1;
      end else begin
        lz = lzc64(s3_sum[65:2]);
        if (s3_sum[65:2] == '0) lz = 6'd63;
        e  = {1'b0, s3_exp};
        // stop at exponent 1 so subnormals keep their denormalized form
        if (e - 13'd1 < {7'd0, lz}) sh = 7'(e - 13'd1);
        else sh = {1'b0, lz};
        s4_sig <= s3_sum << sh;
        s4_exp <= e - {6'd0, sh};
      end
    end
  end

  // ---------------- stage 5: round and select ----------------
  logic        r_valid;
  logic [1:0]  r_tag;
  logic [63:0] r_bits;

  always_ff @(posedge clk) begin
    logic [53:0] m;
    logic        g, st, up;
    logic [12:0] e;
    if (en5) begin
      m  = {1'b0, s4_sig[65:13]};
      g  = s4_sig[12];
      st = |s4_sig[11:0];
      up = g && (st || m[0]);
      m  = m + {53'd0, up};
      e  = s4_exp;
      if (m[53]) begin
        m = m >> 1;
        e = e + 13'd1;
      end
      if (!m[52]) e = 13'd0;
      r_valid <= s4_known;
      if (!s4_known) begin
        r_tag  <= TAG_UNSIGNED;
        r_bits <= '0;
      end else if (!s4_fp) begin
        r_tag  <= s4_itag;
        r_bits <= s4_idiff;
      end else begin
        r_tag <= TAG_DOUBLE;
        if (s4_special)
          r_bits <= s4_spec;
        else if (s4_zero)
          r_bits <= {s4_sign, 63'd0};
        else if (e >= 13'd2047)
          r_bits <= {s4_sign, 11'h7FF, 52'd0};
        else
          r_bits <= {s4_sign, e[10:0], m[51:0]};
      end
    end
  end

  assign valid_res   = r_valid;
  assign result_tag  = r_tag;
  assign result_bits = r_bits;

endmodule
